// ----- hdl/rfe_pkg.sv -----
// Shared types and constants for the rail fence encryptor.
// No dependencies; imported by rfe_zigzag and rail_fence_encrypt_top.
package rfe_pkg;

    localparam int CFG_W = 5;
    localparam int BYTE_W = 8;
    localparam logic [CFG_W-1:0] RAILS_RESET = 5'd3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_TEST,
        ST_EMIT
    } rfe_state_t;

    typedef struct packed {
        logic step;
        logic clear;
    } zz_ctrl_t;

endpackage

// ----- hdl/rfe_zigzag.sv -----
// Zigzag rail counter: clamps the current rail to the live rail count and steps it.
// Depends on rfe_pkg.
module rfe_zigzag #(
    parameter int MAX_RAILS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rfe_pkg::zz_ctrl_t              ctrl,
    input  logic [rfe_pkg::CFG_W-1:0]      rails,
    output logic [$clog2(MAX_RAILS)-1:0]   tag
);
    import rfe_pkg::*;

    localparam int TAG_W = $clog2(MAX_RAILS);
    localparam int RW = (TAG_W + 1 > CFG_W) ? TAG_W + 1 : CFG_W;

    logic [TAG_W-1:0] cur_reg, cur_next;
    logic             up_reg, up_next;
    logic [RW-1:0]    nr;
    logic [RW-1:0]    last_rail;
    logic [RW-1:0]    cur_w;
    logic [RW-1:0]    r_clamped;
    logic [RW-1:0]    r_adv;
    logic             up_adv;

    always_comb begin
        if (rails == '0) begin
            nr = RW'(1);
        end else if (RW'(rails) > RW'(MAX_RAILS)) begin
            nr = RW'(MAX_RAILS);
        end else begin
            nr = RW'(rails);
        end
        last_rail = nr - RW'(1);
        cur_w     = RW'(cur_reg);
        r_clamped = (cur_w > last_rail) ? last_rail : cur_w;
    end

    assign tag = r_clamped[TAG_W-1:0];

    always_comb begin
        r_adv  = r_clamped;
        up_adv = up_reg;
        if (last_rail == '0) begin
            r_adv  = '0;
            up_adv = 1'b0;
        end else if (!up_reg) begin
            if (r_clamped + RW'(1) >= last_rail) begin
                r_adv  = last_rail;
                up_adv = 1'b1;
            end else begin
                r_adv = r_clamped + RW'(1);
            end
        end else begin
            if (r_clamped <= RW'(1)) begin
                r_adv  = '0;
                up_adv = 1'b0;
            end else begin
                r_adv = r_clamped - RW'(1);
            end
        end
    end

    always_comb begin
        cur_next = cur_reg;
        up_next  = up_reg;
        if (ctrl.clear) begin
            cur_next = '0;
            up_next  = 1'b0;
        end else if (ctrl.step) begin
            cur_next = r_adv[TAG_W-1:0];
            up_next  = up_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
            up_reg  <= 1'b0;
        end else begin
            cur_reg <= cur_next;
            up_reg  <= up_next;
        end
    end

endmodule

// ----- hdl/rail_fence_encrypt_top.sv -----
// Rail fence encryptor top level: text buffer, rail scan sequencer and stream ports.
// Depends on rfe_pkg and rfe_zigzag.
// Load: one text word per cycle while s_tready is high.
// Emission after the last word: each rail pass reads every stored entry through one
//   registered memory port and one tag comparator.
// Input is stalled from the last word until the final result word is taken.
// Reset clears control state and sets rails to 3; the text stores are not cleared.
module rail_fence_encrypt_top #(
    parameter int MAX_LEN   = 64,
    parameter int MAX_RAILS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rfe_pkg::CFG_W-1:0]     cfg_wr_data,   // rails
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,       // [7:0] text_byte
    input  logic                          s_tlast,       // is_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,       // [7:0] cipher_byte
    output logic                          m_tlast,       // is_final
    output logic [0:0]                    m_tuser        // [0] truncated
);
    import rfe_pkg::*;

    localparam int TAG_W = $clog2(MAX_RAILS);
    localparam int AW    = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    rfe_state_t         state_reg, state_next;
    logic [CFG_W-1:0]   rails_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [TAG_W-1:0]   srail_reg, srail_next;
    logic [AW-1:0]      emit_reg, emit_next;
    logic [BYTE_W-1:0]  rd_char_reg;
    logic [TAG_W-1:0]   rd_tag_reg;

    logic [BYTE_W-1:0]  char_mem [MAX_LEN];
    logic [TAG_W-1:0]   tag_mem  [MAX_LEN];

    logic               s_acc, m_acc, full, wr_en;
    logic               hit, k_end, is_final, scan_step;
    logic [CNT_W-1:0]   cnt_m1;
    logic [TAG_W-1:0]   zz_tag;
    zz_ctrl_t           zz_ctrl;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign full     = (cnt_reg == CNT_W'(MAX_LEN));
    assign wr_en    = s_acc && !full;
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign hit      = (rd_tag_reg == srail_reg);
    assign k_end    = (CNT_W'(k_reg) == cnt_m1);
    assign is_final = (CNT_W'(emit_reg) == cnt_m1);
    assign scan_step = ((state_reg == ST_TEST) && !hit)
                    || ((state_reg == ST_EMIT) && m_tready && !is_final);

    assign zz_ctrl.step  = wr_en;
    assign zz_ctrl.clear = m_acc && is_final;

    rfe_zigzag #(
        .MAX_RAILS (MAX_RAILS)
    ) u_zigzag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (zz_ctrl),
        .rails   (rails_reg),
        .tag     (zz_tag)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_acc && s_tlast) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_TEST;
            end
            ST_TEST: begin
                state_next = hit ? ST_EMIT : ST_READ;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    state_next = is_final ? ST_LOAD : ST_READ;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_LOAD: s_tready = 1'b1;
            ST_EMIT: m_tvalid = 1'b1;
            default: begin
                s_tready = 1'b0;
                m_tvalid = 1'b0;
            end
        endcase
    end

    assign m_tdata = rd_char_reg;
    assign m_tlast = is_final;
    assign m_tuser = ovf_reg;

    // datapath next values
    always_comb begin
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        srail_next = srail_reg;
        emit_next  = emit_reg;
        if (s_acc) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            k_next     = '0;
            srail_next = '0;
            emit_next  = '0;
        end
        if (scan_step) begin
            if (k_end) begin
                k_next     = '0;
                srail_next = srail_reg + TAG_W'(1);
            end else begin
                k_next = k_reg + AW'(1);
            end
        end
        if (m_acc) begin
            emit_next = emit_reg + AW'(1);
            if (is_final) begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            rails_reg <= RAILS_RESET;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
            srail_reg <= '0;
            emit_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                rails_reg <= cfg_wr_data;
            end
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
            srail_reg <= srail_next;
            emit_reg  <= emit_next;
        end
    end

    // text buffer, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            char_mem[cnt_reg[AW-1:0]] <= s_tdata;
            tag_mem[cnt_reg[AW-1:0]]  <= zz_tag;
        end
        if (state_reg == ST_READ) begin
            rd_char_reg <= char_mem[k_reg];
            rd_tag_reg  <= tag_mem[k_reg];
        end
    end

    a_no_load_during_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while emitting");

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_LEN))
        else $error("stored count beyond buffer depth");

    a_emit_matches_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (rd_tag_reg == srail_reg))
        else $error("word emitted on wrong rail");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (cnt_reg == '0 && !ovf_reg && s_tready))
        else $error("state not cleared after final word");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> (cnt_reg != '0))
        else $error("scan running on empty buffer");

endmodule
